// ----- src/bitmap_page_frame_allocator_defines.svh -----
// Assertion helpers for the allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BPFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bpfa_pkg.sv -----
`timescale 1ns / 1ps

package bpfa_pkg;

   localparam int MAX_PAGES  = 65536;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int TOTAL_W    = PAGE_W + 1;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORDS      = MAX_PAGES / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORDS);

   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 32;
   localparam int STATUS_W = 2;
   localparam int PADDR_W  = 28;
   localparam int CNT_W    = 17;
   localparam int SUM_W    = ADDR_W + 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK_USED = 2'd2;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISALIGN = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

   typedef enum logic [1:0] {
      MODE_FIND,
      MODE_SET,
      MODE_CLEAR
   } word_mode_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] byte_addr;
      logic [LEN_W-1:0]  byte_len;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PADDR_W-1:0]  page_addr;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   typedef struct packed {
      word_mode_type      mode;
      logic [WORD_AW-1:0] widx;
      logic [TOTAL_W-1:0] lo;
      logic [TOTAL_W-1:0] hi;
   } word_cmd_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic                 found;
      logic [BIT_W-1:0]     found_bit;
      logic [BIT_W:0]       change_cnt;
   } word_res_type;

endpackage

// ----- src/bpfa_bitmap_ram.sv -----
`timescale 1ns / 1ps

module bpfa_bitmap_ram import bpfa_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 wr_en,
   input  logic [WORD_AW-1:0]   addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            mem[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bpfa_word_unit.sv -----
`timescale 1ns / 1ps

module bpfa_word_unit import bpfa_pkg::*; (
   input  logic [WORD_BITS-1:0] rd_word,
   input  word_cmd_type         cmd,
   output word_res_type         res
);

   localparam int SEG_W = TOTAL_W - BIT_W;

   logic [SEG_W-1:0]     cur_seg;
   logic [SEG_W-1:0]     lo_seg;
   logic [SEG_W-1:0]     hi_seg;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] hits;
   logic [BIT_W-1:0]     first_bit;

   assign cur_seg = SEG_W'(cmd.widx);
   assign lo_seg  = cmd.lo[TOTAL_W-1:BIT_W];
   assign hi_seg  = cmd.hi[TOTAL_W-1:BIT_W];

   always_comb begin
      lo_mask = (lo_seg == cur_seg) ? ({WORD_BITS{1'b1}} << cmd.lo[BIT_W-1:0]) : '1;
      hi_mask = (hi_seg == cur_seg) ? ~({WORD_BITS{1'b1}} << cmd.hi[BIT_W-1:0]) : '1;
      mask    = lo_mask & hi_mask;
   end

   always_comb begin
      case (cmd.mode)
         MODE_FIND:  hits = ~rd_word & mask;
         MODE_SET:   hits = ~rd_word & mask;
         MODE_CLEAR: hits = rd_word & mask;
         default:    hits = '0;
      endcase
   end

   always_comb begin
      first_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            first_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      res.found      = |hits;
      res.found_bit  = first_bit;
      res.change_cnt = (BIT_W + 1)'($countones(hits));
      case (cmd.mode)
         MODE_FIND:  res.new_word = (|hits) ? (rd_word | (WORD_BITS'(1) << first_bit))
                                            : rd_word;
         MODE_SET:   res.new_word = rd_word | mask;
         MODE_CLEAR: res.new_word = rd_word & ~mask;
         default:    res.new_word = rd_word;
      endcase
   end

endmodule

// ----- src/bitmap_page_frame_allocator.sv -----
// Bitmap page-frame allocator, first fit.
// Commands enter on req_data while start is high and busy is low; the word
// is taken at that clock edge. Ops: allocate, free one page, mark a byte
// region used, mark a byte region free. Each command returns exactly one
// result word on rsp_data, shown for one cycle with rsp_valid high; the
// receiver cannot stall it, and busy stays high until it has been shown.
// csr_wr_en/csr_wr_data write page_total; write it only while idle.
// Sequence: one setup step, then for each 32-page bitmap word visited a read
// and then a masked update and write back (single-port bitmap RAM; an
// allocate that finds no free page in a word writes nothing back), then a
// result step. Allocate scans from word 0 up to the first free page; free
// visits one word; a region mark visits every word it spans. Rejected
// commands go from setup straight to the result. One command at a time.
// Reset: page_total and the free count go to zero and a fill pass writes
// all 2048 bitmap words to all used, with busy high; the CSR is writable
// during that pass.

`timescale 1ns / 1ps

`include "bitmap_page_frame_allocator_defines.svh"

module bitmap_page_frame_allocator import bpfa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_AW-1:0]   clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]     page_total_ff, page_total_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   req_type              req_ff, req_in;
   word_mode_type        mode_ff, mode_in;
   logic [TOTAL_W-1:0]   lo_ff, lo_in;
   logic [TOTAL_W-1:0]   hi_ff, hi_in;
   logic [WORD_AW-1:0]   widx_ff, widx_in;
   logic [WORD_AW-1:0]   last_word_ff, last_word_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [PADDR_W-1:0]   page_addr_ff, page_addr_in;

   logic                 ram_en;
   logic                 ram_we;
   logic [WORD_AW-1:0]   ram_addr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] ram_rdata;

   word_cmd_type         wcmd;
   word_res_type         wres;

   logic [31:0]          total_wide;
   logic [TOTAL_W-1:0]   lim;
   logic [SUM_W-1:0]     first_pg;
   logic [SUM_W-1:0]     end_sum;
   logic [SUM_W-1:0]     last_pg;
   logic [TOTAL_W-1:0]   hi_m1;
   logic [CNT_W-1:0]     chg;
   logic [CNT_W:0]       up_sum;
   logic [63:0]          pg_byte;

   bpfa_bitmap_ram u_ram (
      .clock   (clock),
      .en      (ram_en),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign wcmd.mode = mode_ff;
   assign wcmd.widx = widx_ff;
   assign wcmd.lo   = lo_ff;
   assign wcmd.hi   = hi_ff;

   bpfa_word_unit u_word (
      .rd_word (ram_rdata),
      .cmd     (wcmd),
      .res     (wres)
   );

   always_comb begin
      total_wide = 32'(page_total_ff);
      lim        = TOTAL_W'((total_wide > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : total_wide);
      first_pg   = SUM_W'(req_ff.byte_addr >> PAGE_SHIFT);
      end_sum    = SUM_W'(req_ff.byte_addr) + SUM_W'(req_ff.byte_len)
                 + SUM_W'(PAGE_BYTES - 1);
      last_pg    = end_sum >> PAGE_SHIFT;
      chg        = CNT_W'(wres.change_cnt);
      up_sum     = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(chg);
      pg_byte    = 64'({widx_ff, wres.found_bit}) << PAGE_SHIFT;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      page_total_in = csr_wr_en ? csr_wr_data : page_total_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      mode_in       = mode_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      hi_m1         = '0;
      widx_in       = widx_ff;
      last_word_in  = last_word_ff;
      status_in     = status_ff;
      page_addr_in  = page_addr_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = widx_ff;
      ram_wdata     = wres.new_word;

      case (state_ff)
         S_CLEAR: begin
            ram_en     = 1'b1;
            ram_we     = 1'b1;
            ram_addr   = clr_idx_ff;
            ram_wdata  = '1;
            clr_idx_in = clr_idx_ff + WORD_AW'(1);
            if (clr_idx_ff == WORD_AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            status_in    = STATUS_OK;
            page_addr_in = '0;
            state_in     = S_DONE;
            case (req_ff.op)
               OP_ALLOC: begin
                  mode_in = MODE_FIND;
                  lo_in   = '0;
                  hi_in   = lim;
                  if (count_ff == '0 || lim == '0) begin
                     status_in = STATUS_NO_MEM;
                  end else begin
                     state_in = S_READ;
                  end
               end
               OP_FREE: begin
                  mode_in = MODE_CLEAR;
                  lo_in   = TOTAL_W'(first_pg);
                  hi_in   = TOTAL_W'(first_pg) + TOTAL_W'(1);
                  if (req_ff.byte_addr[PAGE_SHIFT-1:0] != '0) begin
                     status_in = STATUS_MISALIGN;
                  end else if (first_pg >= SUM_W'(lim)) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               OP_MARK_USED, OP_MARK_FREE: begin
                  mode_in = (req_ff.op == OP_MARK_USED) ? MODE_SET : MODE_CLEAR;
                  lo_in   = TOTAL_W'(first_pg);
                  hi_in   = (last_pg > SUM_W'(lim)) ? lim : TOTAL_W'(last_pg);
                  if (first_pg < SUM_W'(hi_in)) begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
            hi_m1        = hi_in - TOTAL_W'(1);
            widx_in      = lo_in[PAGE_W-1:BIT_W];
            last_word_in = hi_m1[PAGE_W-1:BIT_W];
         end
         S_READ: begin
            ram_en   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (mode_ff == MODE_FIND) begin
               if (wres.found) begin
                  ram_en       = 1'b1;
                  ram_we       = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  page_addr_in = pg_byte[PADDR_W-1:0];
                  state_in     = S_DONE;
               end else if (widx_ff == last_word_ff) begin
                  status_in = STATUS_NO_MEM;
                  state_in  = S_DONE;
               end else begin
                  widx_in  = widx_ff + WORD_AW'(1);
                  state_in = S_READ;
               end
            end else begin
               ram_en = 1'b1;
               ram_we = 1'b1;
               if (mode_ff == MODE_SET) begin
                  count_in = (count_ff > chg) ? (count_ff - chg) : '0;
               end else begin
                  count_in = (up_sum > (CNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX
                                                                 : up_sum[CNT_W-1:0];
               end
               if (widx_ff == last_word_ff) begin
                  state_in = S_DONE;
               end else begin
                  widx_in  = widx_ff + WORD_AW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         page_total_ff <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         page_total_ff <= page_total_in;
         count_ff      <= count_in;
      end
      req_ff       <= req_in;
      mode_ff      <= mode_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      widx_ff      <= widx_in;
      last_word_ff <= last_word_in;
      status_ff    <= status_in;
      page_addr_ff <= page_addr_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_data.status     = status_ff;
   assign rsp_data.page_addr  = page_addr_ff;
   assign rsp_data.free_count = count_ff;

   `BPFA_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `BPFA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `BPFA_ASSERT_IMP(a_fail_no_addr, clock, reset, rsp_valid && rsp_data.status != STATUS_OK, rsp_data.page_addr == '0, "address on failed op")
   `BPFA_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == S_EVAL, widx_ff <= last_word_ff, "walk past last word")

endmodule
